/* hdl/qpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared widths, register codes, stage types and step functions of the
// quadric patch evaluator.
// ----------------------------------------------------------------------------
package qpe_pkg;

   localparam int VW   = 24;
   localparam int FB   = 16;
   localparam int CFGW = 2 * VW;
   localparam int IDXW = 3;

   localparam logic [IDXW-1:0] REG_MODE         = 3'd0;
   localparam logic [IDXW-1:0] REG_AFFINE_FIRST = 3'd1;
   localparam logic [IDXW-1:0] REG_AFFINE_SECOND = 3'd2;
   localparam logic [IDXW-1:0] REG_CONST_LIN    = 3'd3;
   localparam logic [IDXW-1:0] REG_SQUARE_CROSS = 3'd4;
   localparam logic [IDXW-1:0] REG_SECOND_AXIS  = 3'd5;

   localparam int MODE_HYP  = 0;
   localparam int MODE_SURF = 1;
   localparam int MODE_NEG  = 2;

   localparam logic [2:0]      MODE_RESET          = 3'b010;
   localparam logic [CFGW-1:0] AFFINE_RESET        = 48'h0200_00FF_0000;
   localparam logic [CFGW-1:0] CONST_LIN_RESET     = 48'h0000_0000_0000;
   localparam logic [CFGW-1:0] SQUARE_CROSS_RESET  = 48'h0000_0001_0000;
   localparam logic [CFGW-1:0] SECOND_AXIS_RESET   = 48'h0100_0000_0000;

   // internal widths
   localparam int PRW  = 2 * VW;
   localparam int GW   = 2 * VW - FB + 2;
   localparam int MW   = VW + GW;
   localparam int PW   = GW + VW - FB;
   localparam int NUMW = GW - 1;
   localparam int ROOT_MIN    = (PW + FB) / 2;
   localparam int SQ_STAGES   = (ROOT_MIN + 1) / 2;
   localparam int ROOTW       = 2 * SQ_STAGES;
   localparam int RADW        = 2 * ROOTW;
   localparam int SREMW       = ROOTW + 3;
   localparam int DIVW_MIN    = NUMW + FB;
   localparam int DV_STAGES   = (DIVW_MIN + 1) / 2;
   localparam int DVDW        = 2 * DV_STAGES;
   localparam int DREMW       = VW + 1;
   localparam int QW          = DIVW_MIN - FB / 2 + 1;
   localparam int QPW         = QW + VW;

   localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
   localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

   typedef logic signed [VW-1:0] val_type;

   typedef struct packed {
      logic    sat;
      val_type v;
   } clip_type;

   typedef struct packed {
      val_type x0;
      val_type x1;
      val_type h;
      val_type du;
      val_type dv;
      logic    sat_x;
      logic    sat_h;
      logic    sat_du;
      logic    sat_dv;
      logic    clamped;
   } side_type;

   typedef struct packed {
      logic [RADW-1:0]         rad;
      logic [SREMW-1:0]        rem;
      logic [ROOTW-1:0]        root;
      logic signed [NUMW-1:0]  num_u;
      logic signed [NUMW-1:0]  num_v;
      side_type                side;
   } sq_type;

   typedef struct packed {
      logic [DVDW-1:0]  dvd_u;
      logic [DVDW-1:0]  dvd_v;
      logic [DREMW-1:0] rem_u;
      logic [DREMW-1:0] rem_v;
      logic [DVDW-1:0]  quo_u;
      logic [DVDW-1:0]  quo_v;
      logic [VW-1:0]    dsr;
      logic             neg_u;
      logic             neg_v;
      side_type         side;
   } dv_type;

   typedef struct packed {
      val_type point_first;
      val_type point_second;
      val_type point_third;
      val_type slope_first_axis;
      val_type slope_second_axis;
      val_type height_slope_u;
      val_type height_slope_v;
      logic    root_clamped;
      logic    saturated;
   } rsp_type;

   function automatic clip_type clip(input logic signed [63:0] v);
      clip_type c;
      if (v > VMAX) begin
         c.sat = 1'b1;
         c.v   = VW'(VMAX);
      end else if (v < VMIN) begin
         c.sat = 1'b1;
         c.v   = VW'(VMIN);
      end else begin
         c.sat = 1'b0;
         c.v   = VW'(v);
      end
      return c;
   endfunction

   // two root digits per stage
   function automatic sq_type sq_step(input sq_type s);
      sq_type           r;
      logic [SREMW-1:0] trial;
      r = s;
      for (int k = 0; k < 2; k++) begin
         r.rem = {r.rem[SREMW-3:0], r.rad[RADW-1 -: 2]};
         r.rad = {r.rad[RADW-3:0], 2'b00};
         trial = SREMW'({r.root, 2'b01});
         if (r.rem >= trial) begin
            r.rem  = r.rem - trial;
            r.root = {r.root[ROOTW-2:0], 1'b1};
         end else begin
            r.root = {r.root[ROOTW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // two quotient bits per stage, both lanes
   function automatic dv_type dv_step(input dv_type s);
      dv_type           r;
      logic [DREMW-1:0] d;
      r = s;
      d = {1'b0, s.dsr};
      for (int k = 0; k < 2; k++) begin
         r.rem_u = {r.rem_u[DREMW-2:0], r.dvd_u[DVDW-1]};
         r.dvd_u = {r.dvd_u[DVDW-2:0], 1'b0};
         if (r.rem_u >= d) begin
            r.rem_u = r.rem_u - d;
            r.quo_u = {r.quo_u[DVDW-2:0], 1'b1};
         end else begin
            r.quo_u = {r.quo_u[DVDW-2:0], 1'b0};
         end
         r.rem_v = {r.rem_v[DREMW-2:0], r.dvd_v[DVDW-1]};
         r.dvd_v = {r.dvd_v[DVDW-2:0], 1'b0};
         if (r.rem_v >= d) begin
            r.rem_v = r.rem_v - d;
            r.quo_v = {r.quo_v[DVDW-2:0], 1'b1};
         end else begin
            r.quo_v = {r.quo_v[DVDW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* hdl/quadric_patch_evaluator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadric_patch_evaluator_unit
// Throughput: one item per cycle while the result side is ready; a stall on
// the result side freezes the whole pipeline, including the 15-stage root and
// 25-stage divider chains.
// Reset: synchronous, clears the stage valid bits and loads the register
// defaults (surface parabola, unit scale two, offset minus one).
// ----------------------------------------------------------------------------
module quadric_patch_evaluator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  qpe_pkg::val_type              req_param_u,
   input  qpe_pkg::val_type              req_param_v,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output qpe_pkg::val_type              rsp_point_first,
   output qpe_pkg::val_type              rsp_point_second,
   output qpe_pkg::val_type              rsp_point_third,
   output qpe_pkg::val_type              rsp_slope_first_axis,
   output qpe_pkg::val_type              rsp_slope_second_axis,
   output qpe_pkg::val_type              rsp_height_slope_u,
   output qpe_pkg::val_type              rsp_height_slope_v,
   output logic                          rsp_root_clamped,
   output logic                          rsp_saturated,
   input  logic                          csr_write_enable,
   input  logic [qpe_pkg::IDXW-1:0]      csr_index,
   input  logic [qpe_pkg::CFGW-1:0]      csr_write_data
);
   import qpe_pkg::*;

   // configuration
   logic [2:0]      mode_ff;
   logic [CFGW-1:0] aff1_ff, aff2_ff, clin_ff, sqcr_ff, sax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         aff1_ff <= AFFINE_RESET;
         aff2_ff <= AFFINE_RESET;
         clin_ff <= CONST_LIN_RESET;
         sqcr_ff <= SQUARE_CROSS_RESET;
         sax_ff  <= SECOND_AXIS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_MODE:          mode_ff <= csr_write_data[2:0];
            REG_AFFINE_FIRST:  aff1_ff <= csr_write_data;
            REG_AFFINE_SECOND: aff2_ff <= csr_write_data;
            REG_CONST_LIN:     clin_ff <= csr_write_data;
            REG_SQUARE_CROSS:  sqcr_ff <= csr_write_data;
            REG_SECOND_AXIS:   sax_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic    hyp, surf, negr;
   val_type c0x, c1x, c0y, c1y, a00, a10, a20, a11, a01, a02;

   assign hyp  = mode_ff[MODE_HYP];
   assign surf = mode_ff[MODE_SURF];
   assign negr = mode_ff[MODE_NEG];
   assign c0x  = aff1_ff[VW-1:0];
   assign c1x  = aff1_ff[CFGW-1:VW];
   assign c0y  = aff2_ff[VW-1:0];
   assign c1y  = aff2_ff[CFGW-1:VW];
   assign a00  = clin_ff[VW-1:0];
   assign a10  = clin_ff[CFGW-1:VW];
   assign a20  = sqcr_ff[VW-1:0];
   assign a11  = sqcr_ff[CFGW-1:VW];
   assign a01  = sax_ff[VW-1:0];
   assign a02  = sax_ff[CFGW-1:VW];

   // pipeline advance
   logic    adv;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: affine products
   logic                  s1_valid_ff;
   logic signed [PRW-1:0] s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff <= c1x * req_param_u;
         s1_py_ff <= c1y * req_param_v;
      end
   end

   // stage 2: affine sums
   clip_type x0_in, x1_in;
   logic     s2_valid_ff, s2_satx_ff;
   val_type  s2_x0_ff, s2_x1_ff;

   always_comb begin
      x0_in = clip(64'(c0x) + 64'(s1_px_ff >>> FB));
      x1_in = clip(64'(c0y) + 64'(s1_py_ff >>> FB));
      if (!surf) begin
         x1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x0_ff   <= x0_in.v;
         s2_x1_ff   <= x1_in.v;
         s2_satx_ff <= x0_in.sat | x1_in.sat;
      end
   end

   // stage 3: coefficient products
   logic                  s3_valid_ff, s3_satx_ff;
   val_type               s3_x0_ff, s3_x1_ff;
   logic signed [PRW-1:0] s3_p20_ff, s3_p11_ff, s3_p02_ff, s3_p11b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_x0_ff   <= s2_x0_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_satx_ff <= s2_satx_ff;
         s3_p20_ff  <= a20 * s2_x0_ff;
         s3_p11_ff  <= a11 * s2_x1_ff;
         s3_p02_ff  <= a02 * s2_x1_ff;
         s3_p11b_ff <= a11 * s2_x0_ff;
      end
   end

   // stage 4: bracket sums
   logic                 s4_valid_ff, s4_satx_ff;
   val_type              s4_x0_ff, s4_x1_ff;
   logic signed [GW-1:0] s4_inner_ff, s4_t1_ff, s4_gu_ff, s4_gv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_x0_ff    <= s3_x0_ff;
         s4_x1_ff    <= s3_x1_ff;
         s4_satx_ff  <= s3_satx_ff;
         s4_inner_ff <= GW'(a10) + GW'(s3_p20_ff >>> FB) + GW'(s3_p11_ff >>> FB);
         s4_t1_ff    <= GW'(a01) + GW'(s3_p02_ff >>> FB);
         s4_gu_ff    <= GW'(a10) + GW'(s3_p20_ff >>> (FB - 1)) + GW'(s3_p11_ff >>> FB);
         s4_gv_ff    <= GW'(a01) + GW'(s3_p02_ff >>> (FB - 1)) + GW'(s3_p11b_ff >>> FB);
      end
   end

   // stage 5: outer products and parabola slopes
   logic                 s5_valid_ff, s5_satx_ff;
   val_type              s5_x0_ff, s5_x1_ff;
   logic signed [GW-1:0] s5_gu_ff, s5_gv_ff;
   logic signed [MW-1:0] s5_m0_ff, s5_m1_ff, s5_mu_ff, s5_mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_x0_ff   <= s4_x0_ff;
         s5_x1_ff   <= s4_x1_ff;
         s5_satx_ff <= s4_satx_ff;
         s5_gu_ff   <= s4_gu_ff;
         s5_gv_ff   <= s4_gv_ff;
         s5_m0_ff   <= s4_x0_ff * s4_inner_ff;
         s5_m1_ff   <= s4_x1_ff * s4_t1_ff;
         s5_mu_ff   <= s4_gu_ff * c1x;
         s5_mv_ff   <= s4_gv_ff * c1y;
      end
   end

   // stage 6: polynomial, root operand
   logic signed [PW-1:0] poly;
   logic signed [PW-1:0] arg;
   clip_type             hp, dup, dvp;
   sq_type               sq_in;

   always_comb begin
      poly  = PW'(a00) + PW'(s5_m0_ff >>> FB) + PW'(s5_m1_ff >>> FB);
      arg   = (poly < 1) ? PW'(1) : poly;
      hp    = clip(64'(poly));
      dup   = clip(64'(s5_mu_ff >>> FB));
      dvp   = clip(64'(s5_mv_ff >>> FB));
      sq_in.rad   = RADW'({arg[PW-2:0], FB'(0)});
      sq_in.rem   = '0;
      sq_in.root  = '0;
      sq_in.num_u = NUMW'(s5_gu_ff >>> 1);
      sq_in.num_v = NUMW'(s5_gv_ff >>> 1);
      sq_in.side.x0      = s5_x0_ff;
      sq_in.side.x1      = s5_x1_ff;
      sq_in.side.h       = hp.v;
      sq_in.side.du      = dup.v;
      sq_in.side.dv      = dvp.v;
      sq_in.side.sat_x   = s5_satx_ff;
      sq_in.side.sat_h   = hp.sat;
      sq_in.side.sat_du  = dup.sat;
      sq_in.side.sat_dv  = dvp.sat;
      sq_in.side.clamped = hyp && (poly < 1);
   end

   // square root chain
   sq_type sq_ff  [SQ_STAGES+1];
   logic   sqv_ff [SQ_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SQ_STAGES; i++) begin
            sqv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         sqv_ff[0] <= s5_valid_ff;
         for (int i = 0; i < SQ_STAGES; i++) begin
            sqv_ff[i+1] <= sqv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0] <= sq_in;
         for (int i = 0; i < SQ_STAGES; i++) begin
            sq_ff[i+1] <= sq_step(sq_ff[i]);
         end
      end
   end

   // signed height and divider operands
   logic signed [63:0] root_s;
   clip_type           hh;
   dv_type             dv_in;
   logic [NUMW-1:0]    mag_u, mag_v;

   always_comb begin
      root_s = signed'(64'(sq_ff[SQ_STAGES].root));
      hh     = clip(negr ? -root_s : root_s);
      dv_in.side = sq_ff[SQ_STAGES].side;
      if (hyp) begin
         dv_in.side.h     = hh.v;
         dv_in.side.sat_h = hh.sat;
      end
      mag_u = sq_ff[SQ_STAGES].num_u[NUMW-1] ? NUMW'(-sq_ff[SQ_STAGES].num_u)
                                             : NUMW'(sq_ff[SQ_STAGES].num_u);
      mag_v = sq_ff[SQ_STAGES].num_v[NUMW-1] ? NUMW'(-sq_ff[SQ_STAGES].num_v)
                                             : NUMW'(sq_ff[SQ_STAGES].num_v);
      dv_in.dvd_u = DVDW'({mag_u, FB'(0)});
      dv_in.dvd_v = DVDW'({mag_v, FB'(0)});
      dv_in.rem_u = '0;
      dv_in.rem_v = '0;
      dv_in.quo_u = '0;
      dv_in.quo_v = '0;
      dv_in.dsr   = hh.v[VW-1] ? VW'(-hh.v) : VW'(hh.v);
      dv_in.neg_u = sq_ff[SQ_STAGES].num_u[NUMW-1] ^ hh.v[VW-1];
      dv_in.neg_v = sq_ff[SQ_STAGES].num_v[NUMW-1] ^ hh.v[VW-1];
   end

   // divider chain
   dv_type dv_ff  [DV_STAGES+1];
   logic   dvv_ff [DV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DV_STAGES; i++) begin
            dvv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dvv_ff[0] <= sqv_ff[SQ_STAGES];
         for (int i = 0; i < DV_STAGES; i++) begin
            dvv_ff[i+1] <= dvv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv_in;
         for (int i = 0; i < DV_STAGES; i++) begin
            dv_ff[i+1] <= dv_step(dv_ff[i]);
         end
      end
   end

   // quotient scaling
   logic signed [QW-1:0]  qmag_u, qmag_v, qu, qv;
   logic                  sm_valid_ff;
   side_type              sm_side_ff;
   logic signed [QPW-1:0] sm_pu_ff, sm_pv_ff;

   always_comb begin
      qmag_u = signed'({1'b0, dv_ff[DV_STAGES].quo_u[QW-2:0]});
      qmag_v = signed'({1'b0, dv_ff[DV_STAGES].quo_v[QW-2:0]});
      qu     = dv_ff[DV_STAGES].neg_u ? -qmag_u : qmag_u;
      qv     = dv_ff[DV_STAGES].neg_v ? -qmag_v : qmag_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_valid_ff <= 1'b0;
      end else if (adv) begin
         sm_valid_ff <= dvv_ff[DV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_side_ff <= dv_ff[DV_STAGES].side;
         sm_pu_ff   <= qu * c1x;
         sm_pv_ff   <= qv * c1y;
      end
   end

   // result selection
   clip_type duh, dvh;
   val_type  du, dv;
   logic     sat_du, sat_dv;

   always_comb begin
      duh    = clip(64'(sm_pu_ff >>> FB));
      dvh    = clip(64'(sm_pv_ff >>> FB));
      du     = hyp ? duh.v : sm_side_ff.du;
      dv     = hyp ? dvh.v : sm_side_ff.dv;
      sat_du = hyp ? duh.sat : sm_side_ff.sat_du;
      sat_dv = hyp ? dvh.sat : sm_side_ff.sat_dv;
      rsp_in.point_first       = sm_side_ff.x0;
      rsp_in.point_second      = surf ? sm_side_ff.x1 : sm_side_ff.h;
      rsp_in.point_third       = surf ? sm_side_ff.h : '0;
      rsp_in.slope_first_axis  = c1x;
      rsp_in.slope_second_axis = surf ? c1y : '0;
      rsp_in.height_slope_u    = du;
      rsp_in.height_slope_v    = surf ? dv : '0;
      rsp_in.root_clamped      = sm_side_ff.clamped;
      rsp_in.saturated         = sm_side_ff.sat_x | sm_side_ff.sat_h | sat_du
                                 | (surf & sat_dv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_point_first       = rsp_ff.point_first;
   assign rsp_point_second      = rsp_ff.point_second;
   assign rsp_point_third       = rsp_ff.point_third;
   assign rsp_slope_first_axis  = rsp_ff.slope_first_axis;
   assign rsp_slope_second_axis = rsp_ff.slope_second_axis;
   assign rsp_height_slope_u    = rsp_ff.height_slope_u;
   assign rsp_height_slope_v    = rsp_ff.height_slope_v;
   assign rsp_root_clamped      = rsp_ff.root_clamped;
   assign rsp_saturated         = rsp_ff.saturated;

endmodule
